// ----- rtl/pebr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pebr_pkg
// Shared types and constants of the relocation directory parser.
// ----------------------------------------------------------------------------
package pebr_pkg;

    // input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_FIXUP = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_DIR    = 2'd0;
    localparam logic [1:0] ERR_BLOCK  = 2'd1;
    localparam logic [1:0] ERR_TARGET = 2'd2;
    localparam logic [1:0] ERR_TYPE   = 2'd3;

    // register indexes (byte address 8*i)
    localparam logic [1:0] REG_DELTA       = 2'd0;
    localparam logic [1:0] REG_DIR_PRESENT = 2'd1;
    localparam logic [1:0] REG_DIR_SIZE    = 2'd2;
    localparam logic [1:0] REG_IMAGE_SIZE  = 2'd3;
    localparam int unsigned APB_AW         = 5;

    // entry layout
    localparam logic [3:0]  TYPE_ABS    = 4'd0;
    localparam logic [3:0]  TYPE_DIR64  = 4'd10;
    localparam int unsigned OFFSET_BITS = 12;
    localparam logic [31:0] HDR_BYTES   = 32'd8;
    localparam logic [31:0] WORD_BYTES  = 32'd8;

    // result queue
    localparam int unsigned RQ_AW    = 2;
    localparam int unsigned RQ_DEPTH = 1 << RQ_AW;

    typedef struct packed {
        logic [63:0] delta;
        logic        dir_present;
        logic [31:0] dir_size;
        logic [31:0] image_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] target_offset;
        logic [1:0]  error_code;
    } res_t;

    // up to two results per item, first in r0
    typedef struct packed {
        logic [1:0] n;
        res_t       r0;
        res_t       r1;
    } push_t;

endpackage : pebr_pkg
`default_nettype wire

// ----- rtl/pe_base_relocation_parser_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pe_base_relocation_parser_core
// PE base-relocation directory parser emitting DIR64 fixup commands.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result queue has room: a start command
// or one directory byte. Each item is registered at the input and parsed once
// the queue has room for a pair; its results are then written into the
// result queue and show on m_. An item yields at most two results (a
// fixup followed by done); the four-entry result queue accepts a new item as
// long as it has room for a pair, so the input only stalls when results back
// up or more than one result per item is produced on average. Errors are
// sticky until the next start. Registers sit at byte addresses 0, 8, 16, 24
// on the 64-bit APB port and should only be written while the parser is idle.
// ----------------------------------------------------------------------------
module pe_base_relocation_parser_core
    import pebr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // config
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [7:0]        s_data_byte,
    // result items
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [31:0]            m_target_offset,
    output logic [1:0]             m_error_code
);

    cfg_t  cfg;
    push_t push;
    logic  room;

    pebr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pebr_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .cfg         (cfg),
        .room        (room),
        .push        (push)
    );

    pebr_resq u_resq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .push            (push),
        .room            (room),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_target_offset (m_target_offset),
        .m_error_code    (m_error_code)
    );

    // results only pushed when the queue has space for a pair
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> room)
        else $error("result pushed into full queue");

    a_err_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_ERROR) |-> (m_target_offset == 32'd0))
        else $error("error item carries a target");

    a_ok_no_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_ERROR) |-> (m_error_code == ERR_DIR))
        else $error("non-error item carries an error code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule : pe_base_relocation_parser_core
`default_nettype wire

// ----- rtl/pebr_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pebr_regs
// APB register file: delta, dir_present, dir_size, image_size.
// ----------------------------------------------------------------------------
module pebr_regs
    import pebr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[APB_AW-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DELTA:       cfg_next.delta       = pwdata;
                REG_DIR_PRESENT: cfg_next.dir_present = pwdata[0];
                REG_DIR_SIZE:    cfg_next.dir_size    = pwdata[31:0];
                REG_IMAGE_SIZE:  cfg_next.image_size  = pwdata[31:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DELTA:       prdata = cfg_reg.delta;
            REG_DIR_PRESENT: prdata = {63'd0, cfg_reg.dir_present};
            REG_DIR_SIZE:    prdata = {32'd0, cfg_reg.dir_size};
            REG_IMAGE_SIZE:  prdata = {32'd0, cfg_reg.image_size};
            default:         prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : pebr_regs
`default_nettype wire

// ----- rtl/pebr_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pebr_parse
// Input register and single-pass parse of one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module pebr_parse
    import pebr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd,
    input  wire logic [7:0] s_data_byte,
    input  wire cfg_t       cfg,
    input  wire logic       room,
    output push_t           push
);

    logic        in_vld_reg, in_vld_next;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;

    logic        active_reg, active_next;
    logic [31:0] off_reg, off_next;          // byte_count - block_start
    logic [31:0] byte_count_reg, byte_count_next;
    logic [31:0] block_start_reg, block_start_next;
    logic [31:0] page_offset_reg, page_offset_next;
    logic [31:0] block_length_reg, block_length_next;
    logic [7:0]  entry_low_reg, entry_low_next;

    logic        fire;
    logic        hdr_ok, in_page, in_len, last_hdr, bad_block, blk_end;
    logic        tgt_oob, last_byte, err, fix;
    logic [1:0]  err_code;
    logic [31:0] page_new, len_new, len_eff, target, bc_inc, off_inc;
    logic [15:0] entry;
    logic [3:0]  etype;
    res_t        r_err, r_fix, r_done;

    assign fire    = in_vld_reg && room;
    assign s_ready = !in_vld_reg || fire;

    assign in_vld_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    // --- byte decode ---
    assign hdr_ok   = ({1'b0, block_start_reg} + {1'b0, HDR_BYTES}) <= {1'b0, cfg.dir_size};
    assign in_page  = (off_reg[31:2] == 30'd0);
    assign in_len   = (off_reg[31:3] == 29'd0) && off_reg[2];
    assign last_hdr = (off_reg == HDR_BYTES - 32'd1);

    always_comb begin
        page_new = page_offset_reg;
        len_new  = block_length_reg;
        case (off_reg[1:0])
            2'd0: begin
                page_new[7:0]   = in_byte_reg;
                len_new[7:0]    = in_byte_reg;
            end
            2'd1: begin
                page_new[15:8]  = in_byte_reg;
                len_new[15:8]   = in_byte_reg;
            end
            2'd2: begin
                page_new[23:16] = in_byte_reg;
                len_new[23:16]  = in_byte_reg;
            end
            default: begin
                page_new[31:24] = in_byte_reg;
                len_new[31:24]  = in_byte_reg;
            end
        endcase
    end

    assign bad_block = (len_new < HDR_BYTES) ||
                       (({1'b0, block_start_reg} + {1'b0, len_new}) > {1'b0, cfg.dir_size});

    assign entry   = {in_byte_reg, entry_low_reg};
    assign etype   = entry[15:12];
    assign target  = page_offset_reg + {{(32-OFFSET_BITS){1'b0}}, entry[OFFSET_BITS-1:0]};
    assign tgt_oob = ({1'b0, target} + {1'b0, WORD_BYTES}) > {1'b0, cfg.image_size};

    assign len_eff   = in_len ? len_new : block_length_reg;
    assign off_inc   = off_reg + 32'd1;
    assign blk_end   = (off_reg >= HDR_BYTES - 32'd1) && (off_inc == len_eff);
    assign bc_inc    = byte_count_reg + 32'd1;
    assign last_byte = (bc_inc >= cfg.dir_size);

    assign r_fix  = '{kind: KIND_FIXUP, target_offset: target, error_code: ERR_DIR};
    assign r_done = '{kind: KIND_DONE, target_offset: 32'd0, error_code: ERR_DIR};
    assign r_err  = '{kind: KIND_ERROR, target_offset: 32'd0, error_code: err_code};

    // --- next state and results ---
    always_comb begin
        active_next       = active_reg;
        off_next          = off_reg;
        byte_count_next   = byte_count_reg;
        block_start_next  = block_start_reg;
        page_offset_next  = page_offset_reg;
        block_length_next = block_length_reg;
        entry_low_next    = entry_low_reg;
        err               = 1'b0;
        err_code          = ERR_DIR;
        fix               = 1'b0;
        push              = '0;

        if (fire) begin
            if (in_cmd_reg == CMD_START) begin
                active_next       = 1'b0;
                off_next          = 32'd0;
                byte_count_next   = 32'd0;
                block_start_next  = 32'd0;
                page_offset_next  = 32'd0;
                block_length_next = 32'd0;
                entry_low_next    = 8'd0;
                if (cfg.delta == 64'd0) begin
                    push.n  = 2'd1;
                    push.r0 = r_done;
                end else if (!cfg.dir_present || cfg.dir_size < HDR_BYTES) begin
                    push.n  = 2'd1;
                    push.r0 = r_err;
                end else begin
                    active_next = 1'b1;
                end
            end else if (active_reg) begin
                off_next = off_inc;
                if (hdr_ok) begin
                    if (in_page) begin
                        page_offset_next = page_new;
                    end else if (in_len) begin
                        block_length_next = len_new;
                        if (last_hdr && bad_block) begin
                            err      = 1'b1;
                            err_code = ERR_BLOCK;
                        end
                    end else if (!off_reg[0]) begin
                        entry_low_next = in_byte_reg;
                    end else if (etype == TYPE_DIR64) begin
                        if (tgt_oob) begin
                            err      = 1'b1;
                            err_code = ERR_TARGET;
                        end else begin
                            fix = 1'b1;
                        end
                    end else if (etype != TYPE_ABS) begin
                        err      = 1'b1;
                        err_code = ERR_TYPE;
                    end
                    if (blk_end) begin
                        block_start_next = block_start_reg + len_eff;
                        off_next         = 32'd0;
                    end
                end

                if (err) begin
                    active_next = 1'b0;
                    push.n      = 2'd1;
                    push.r0     = r_err;
                end else begin
                    byte_count_next = bc_inc;
                    if (fix) begin
                        push.r0 = r_fix;
                    end
                    if (last_byte) begin
                        active_next = 1'b0;
                        if (fix) begin
                            push.r1 = r_done;
                        end else begin
                            push.r0 = r_done;
                        end
                    end
                    push.n = {1'b0, fix} + {1'b0, last_byte};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            active_reg       <= 1'b0;
            off_reg          <= 32'd0;
            byte_count_reg   <= 32'd0;
            block_start_reg  <= 32'd0;
            page_offset_reg  <= 32'd0;
            block_length_reg <= 32'd0;
            entry_low_reg    <= 8'd0;
        end else begin
            in_vld_reg       <= in_vld_next;
            active_reg       <= active_next;
            off_reg          <= off_next;
            byte_count_reg   <= byte_count_next;
            block_start_reg  <= block_start_next;
            page_offset_reg  <= page_offset_next;
            block_length_reg <= block_length_next;
            entry_low_reg    <= entry_low_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_data_byte;
        end
    end

endmodule : pebr_parse
`default_nettype wire

// ----- rtl/pebr_resq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pebr_resq
// Small result queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module pebr_resq
    import pebr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire push_t       push,
    output logic             room,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [31:0]      m_target_offset,
    output logic [1:0]       m_error_code
);

    res_t             q_reg [RQ_DEPTH];
    logic [RQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_AW:0]   count_reg, count_next;
    logic [RQ_AW-1:0] wr_ptr_1;
    logic             pop;
    res_t             head;

    // room for a full pair of results
    assign room     = (count_reg <= (RQ_AW+1)'(RQ_DEPTH - 2));
    assign m_valid  = (count_reg != '0);
    assign pop      = m_valid && m_ready;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;
    assign head     = q_reg[rd_ptr_reg];

    assign m_kind          = head.kind;
    assign m_target_offset = head.target_offset;
    assign m_error_code    = head.error_code;

    assign wr_ptr_next = wr_ptr_reg + RQ_AW'(push.n);
    assign rd_ptr_next = rd_ptr_reg + RQ_AW'(pop);
    assign count_next  = count_reg + (RQ_AW+1)'(push.n) - (RQ_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2) begin
            q_reg[wr_ptr_1] <= push.r1;
        end
    end

endmodule : pebr_resq
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base-relocation directory parser core.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a valid/ready driver. Each accepted item is
// run through a bit-accurate predictor, which queues the fixup, error and
// done results it expects. A monitor compares every result field by field,
// oldest first. Registers go in over APB between phases, once nothing is in
// flight, and are read back. A short directed part covers the corner cases,
// then phases of random directories run under extreme and random settings.
// Both sides throttle at random, with unthrottled stretches in between.
// ----------------------------------------------------------------------------
module tb
    import pebr_pkg::*;
();

    localparam int unsigned RUN_LIMIT_NS  = 4_000_000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned MAX_WAIT      = 16;
    localparam int unsigned PRINT_LIMIT   = 40;
    localparam int unsigned ITEM_TARGET   = 1500;
    localparam logic [1:0]  NO_CODE       = 2'd0;
    localparam logic [31:0] NO_TARGET     = 32'd0;
    localparam logic [31:0] PAGE_SPAN     = 32'h1007;  // max offset plus word

    typedef struct {
        logic       cmd;
        logic [7:0] data;
    } feed_item_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [63:0]       pwdata  = '0;
    logic [63:0]       prdata;
    logic              pready;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_cmd       = CMD_START;
    logic [7:0]        s_data_byte = 8'd0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [1:0]        m_kind;
    logic [31:0]       m_target_offset;
    logic [1:0]        m_error_code;

    feed_item_t  dir_stream_q[$];
    res_t        expected_res_q[$];

    // register copy and parser state of the predictor
    cfg_t        reg_shadow    = '0;
    logic        ps_active     = 1'b0;
    logic        ps_failed     = 1'b0;
    logic [31:0] ps_consumed   = '0;
    logic [31:0] ps_block_base = '0;
    logic [31:0] ps_page       = '0;
    logic [31:0] ps_block_len  = '0;
    logic [7:0]  ps_entry_lo   = '0;

    int unsigned items_queued    = 0;
    int unsigned items_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned fixups_seen     = 0;
    int unsigned errors_seen     = 0;
    int unsigned dones_seen      = 0;
    int unsigned settings_run    = 0;
    int unsigned fault_count     = 0;
    int unsigned feed_gap        = 0;
    int unsigned feed_calm       = 0;
    int unsigned sink_wait       = 0;
    int unsigned sink_calm       = 0;

    pe_base_relocation_parser_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_target_offset (m_target_offset),
        .m_error_code    (m_error_code)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        fault_count++;
        if (fault_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic note_result(input logic [1:0] kind, input logic [31:0] tgt,
                               input logic [1:0] code);
        res_t r;
        r.kind          = kind;
        r.target_offset = tgt;
        r.error_code    = code;
        expected_res_q.push_back(r);
    endtask

    task automatic raise_fault(input logic [1:0] code);
        ps_failed = 1'b1;
        ps_active = 1'b0;
        note_result(KIND_ERROR, NO_TARGET, code);
    endtask

    task automatic parse_reloc_byte(input logic cmd, input logic [7:0] b);
        logic [31:0] off;
        logic [31:0] tgt;
        logic [15:0] entry;
        if (cmd == CMD_START) begin
            ps_active     = 1'b0;
            ps_failed     = 1'b0;
            ps_consumed   = '0;
            ps_block_base = '0;
            ps_page       = '0;
            ps_block_len  = '0;
            ps_entry_lo   = '0;
            if (reg_shadow.delta == 64'd0)
                note_result(KIND_DONE, NO_TARGET, NO_CODE);
            else if (!reg_shadow.dir_present || reg_shadow.dir_size < HDR_BYTES)
                raise_fault(ERR_DIR);
            else
                ps_active = 1'b1;
            return;
        end
        if (!ps_active || ps_failed) return;

        off = ps_consumed - ps_block_base;
        // trailing bytes too few for a header are only counted
        if ({1'b0, ps_block_base} + {1'b0, HDR_BYTES} <= {1'b0, reg_shadow.dir_size}) begin
            if (off < 32'd4) begin
                ps_page[off[1:0]*8 +: 8] = b;
            end else if (off < HDR_BYTES) begin
                ps_block_len[off[1:0]*8 +: 8] = b;
                if (off == HDR_BYTES - 32'd1 &&
                    (ps_block_len < HDR_BYTES ||
                     {1'b0, ps_block_base} + {1'b0, ps_block_len} >
                     {1'b0, reg_shadow.dir_size})) begin
                    raise_fault(ERR_BLOCK);
                    return;
                end
            end else if (!off[0]) begin
                ps_entry_lo = b;
            end else begin
                entry = {b, ps_entry_lo};
                if (entry[15:12] == TYPE_DIR64) begin
                    tgt = ps_page + {20'd0, entry[11:0]};
                    if ({1'b0, tgt} + {1'b0, WORD_BYTES} > {1'b0, reg_shadow.image_size}) begin
                        raise_fault(ERR_TARGET);
                        return;
                    end
                    note_result(KIND_FIXUP, tgt, NO_CODE);
                end else if (entry[15:12] != TYPE_ABS) begin
                    raise_fault(ERR_TYPE);
                    return;
                end
            end
            if (off >= HDR_BYTES - 32'd1 && off + 32'd1 == ps_block_len)
                ps_block_base = ps_block_base + ps_block_len;
        end
        ps_consumed = ps_consumed + 32'd1;
        if (ps_consumed >= reg_shadow.dir_size) begin
            ps_active = 1'b0;
            note_result(KIND_DONE, NO_TARGET, NO_CODE);
        end
    endtask

    // ------------------------------------------------------------------------
    // input driver and result monitor
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : feed_driver
        feed_item_t next_item;
        logic       next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                parse_reloc_byte(s_cmd, s_data_byte);
                items_accepted++;
                next_valid = 1'b0;
                if (feed_calm > 0) begin
                    feed_calm--;
                    feed_gap = 0;
                end else begin
                    feed_gap = $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 31) == 0) feed_calm = $urandom_range(16, 96);
                end
            end
            if (!next_valid) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (dir_stream_q.size() > 0) begin
                    next_item   = dir_stream_q.pop_front();
                    s_cmd       <= next_item.cmd;
                    s_data_byte <= next_item.data;
                    next_valid  = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    always @(posedge aclk) begin : result_monitor
        res_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                case (m_kind)
                    KIND_FIXUP: fixups_seen++;
                    KIND_ERROR: errors_seen++;
                    default:    dones_seen++;
                endcase
                if (expected_res_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d target %h code %0d",
                                              m_kind, m_target_offset, m_error_code));
                end else begin
                    want = expected_res_q.pop_front();
                    results_checked++;
                    if (m_kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_kind, want.kind));
                    if (m_target_offset !== want.target_offset)
                        report_mismatch($sformatf("target %h, want %h",
                                                  m_target_offset, want.target_offset));
                    if (m_error_code !== want.error_code)
                        report_mismatch($sformatf("error code %0d, want %0d",
                                                  m_error_code, want.error_code));
                end
                if (sink_calm > 0) begin
                    sink_calm--;
                    sink_wait = 0;
                end else begin
                    sink_wait = $urandom_range(0, MAX_WAIT);
                    if ($urandom_range(0, 31) == 0) sink_calm = $urandom_range(16, 96);
                end
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // register access
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DELTA:       reg_shadow.delta       = val;
            REG_DIR_PRESENT: reg_shadow.dir_present = val[0];
            REG_DIR_SIZE:    reg_shadow.dir_size    = val[31:0];
            default:         reg_shadow.image_size  = val[31:0];
        endcase
    endtask

    task automatic apb_read_check(input logic [1:0] idx, input logic [63:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // upper bits carry junk, the block keeps only the register width
    task automatic set_registers(input logic [63:0] d, input logic present,
                                 input logic [31:0] dsize, input logic [31:0] isize);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        apb_write(REG_DELTA, d);
        apb_write(REG_DIR_PRESENT, {junk[63:1], present});
        apb_write(REG_DIR_SIZE, {junk[31:0], dsize});
        apb_write(REG_IMAGE_SIZE, {junk[63:32], isize});
        apb_read_check(REG_DELTA, reg_shadow.delta);
        apb_read_check(REG_DIR_PRESENT, {63'd0, reg_shadow.dir_present});
        apb_read_check(REG_DIR_SIZE, {32'd0, reg_shadow.dir_size});
        apb_read_check(REG_IMAGE_SIZE, {32'd0, reg_shadow.image_size});
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_start();
        dir_stream_q.push_back('{CMD_START, 8'($urandom())});
        items_queued++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        dir_stream_q.push_back('{CMD_BYTE, b});
        items_queued++;
    endtask

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
    endtask

    task automatic push_noise();
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom()));
    endtask

    // page mostly chosen so that every offset in it stays inside the image
    function automatic logic [31:0] pick_page();
        if (reg_shadow.image_size < PAGE_SPAN || $urandom_range(0, 7) == 0) return $urandom();
        return $urandom_range(0, reg_shadow.image_size - PAGE_SPAN);
    endfunction

    task automatic emit_directory(input logic [31:0] len, input int unsigned cap);
        int unsigned left;
        int unsigned n_ent;
        int unsigned bsize;
        int unsigned roll;
        logic [31:0] hdr_len;
        logic [11:0] ofs;
        logic [3:0]  etype;
        push_start();
        left = (len > cap) ? cap : len;
        while (left >= 8) begin
            if ($urandom_range(0, 24) == 0) return;  // abandoned, next start restarts
            n_ent = (left - 8) / 2;
            if (n_ent > 10) n_ent = 10;
            n_ent = $urandom_range(0, n_ent);
            bsize = 8 + 2 * n_ent;
            if (bsize < left && $urandom_range(0, 3) == 0) bsize++;
            hdr_len = bsize;
            roll = $urandom_range(0, 49);
            if (roll == 0) hdr_len = $urandom_range(0, 7);
            else if (roll == 1) hdr_len = left + $urandom_range(1, 64);
            push_word(pick_page());
            push_word(hdr_len);
            left -= 8;
            if (roll <= 1) begin
                push_noise();
                return;
            end
            for (int e = 0; e < n_ent; e++) begin
                roll = $urandom_range(0, 99);
                ofs  = 12'($urandom());
                if (roll < 72) begin
                    etype = TYPE_DIR64;
                end else if (roll < 97) begin
                    etype = TYPE_ABS;
                end else begin
                    etype = 4'($urandom_range(1, 15));
                    if (etype == TYPE_DIR64) etype = TYPE_DIR64 + 4'd1;
                end
                push_byte(ofs[7:0]);
                push_byte({etype, ofs[11:8]});
                left -= 2;
                if (etype != TYPE_DIR64 && etype != TYPE_ABS) begin
                    push_noise();
                    return;
                end
            end
            if ((bsize % 2) == 1) begin
                push_byte(8'($urandom()));
                left--;
            end
        end
        while (left > 0) begin
            push_byte(8'($urandom()));
            left--;
        end
    endtask

    // waits until every item is in and every result out, then lets it settle
    task automatic drain();
        while (items_accepted != items_queued || expected_res_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [63:0] d, input logic present,
                             input logic [31:0] dsize, input logic [31:0] isize,
                             input int unsigned budget);
        int unsigned first;
        set_registers(d, present, dsize, isize);
        first = items_queued;
        while (items_queued - first < budget) begin
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom()));
            if ($urandom_range(0, 19) == 0) push_start();
            emit_directory(dsize, budget - (items_queued - first));
        end
        drain();
    endtask

    initial begin : sequencer
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero delta after reset: done at once, then a byte while idle
        push_start();
        push_byte(8'hFF);
        drain();

        // no directory, then one shorter than a header
        set_registers(64'h8000_0000_0000_0000, 1'b0, 32'd16, 32'h2007);
        push_start();
        drain();
        set_registers(64'h8000_0000_0000_0000, 1'b1, 32'd7, 32'h2007);
        push_start();
        drain();

        // one odd-sized block: top offset landing on the last word, padding,
        // an unused odd byte, then trailing bytes short of a header
        set_registers(64'h8000_0000_0000_0000, 1'b1, 32'd16, 32'h2007);
        push_start();
        push_word(32'h0000_1000);
        push_word(32'd13);
        push_byte(8'hFF);
        push_byte({TYPE_DIR64, 4'hF});
        push_byte(8'h00);
        push_byte({TYPE_ABS, 4'h0});
        push_byte(8'h5A);
        push_word(32'h0003_0201);
        drain();

        // shrink the directory below the bytes already taken: done on next byte
        push_start();
        push_byte(8'h00);
        push_byte(8'hA5);
        push_byte(8'h00);
        drain();
        apb_write(REG_DIR_SIZE, 64'd2);
        push_byte(8'h3C);
        drain();

        run_phase({$urandom(), $urandom()}, 1'b1, 32'd64, 32'h0001_0000, 150);
        run_phase(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd8, 32'hFFFF_FFFF, 100);
        run_phase(64'd1, 1'b1, 32'd9, 32'h0000_2000, 80);
        run_phase(64'd0, 1'b1, 32'd40, 32'h0001_0000, 30);
        run_phase({$urandom(), $urandom()}, 1'b0, 32'd40, 32'h0001_0000, 20);
        run_phase({$urandom(), $urandom()}, 1'b1, 32'd0, 32'd0, 10);
        run_phase({$urandom(), $urandom()}, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
        run_phase({$urandom(), $urandom()}, 1'b1, $urandom_range(100, 300), 32'd0, 60);
        while (items_queued < ITEM_TARGET)
            run_phase({$urandom(), $urandom()}, 1'b1, $urandom_range(16, 200),
                      $urandom_range(32'h1008, 32'h0010_0000), 150);

        if (expected_res_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_res_q.size()));
        $display("Run covered %0d items under %0d register settings.",
                 items_accepted, settings_run);
        $display("Checked %0d results: %0d fixups, %0d errors, %0d done.",
                 results_checked, fixups_seen, errors_seen, dones_seen);
        if (fault_count == 0) begin
            $display("pe_base_relocation_parser_core verification clean");
        end else begin
            $display("pe_base_relocation_parser_core verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d items queued, %0d accepted, %0d results pending.",
                 items_queued, items_accepted, expected_res_q.size());
        $display("pe_base_relocation_parser_core verification failed");
        $finish;
    end

endmodule
